// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the keyframe table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define KTI_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("keyframe table check failed");

// Check that a condition in one cycle implies another in the same cycle
`define KTI_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("keyframe table check failed");

// Check that a condition in one cycle implies another in the next cycle
`define KTI_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("keyframe table check failed");

`endif

// ----- rtl/core/kti_pkg.sv -----
// Shared types and constants of the keyframe table interpolator
`timescale 1ns / 1ps
package kti_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int TIME_W    = 16;
    localparam int FRAC_W    = 17;

    // register map
    localparam logic [2:0] ADDR_FIXED = 3'd0;

    typedef enum logic [2:0] {
        CMD_SAMPLE   = 3'd0,
        CMD_SET_TIME = 3'd1,
        CMD_SET_IDX  = 3'd2,
        CMD_INSERT   = 3'd3,
        CMD_REMOVE   = 3'd4,
        CMD_RESIZE   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     time_en;
    } t_cell_ctl;

endpackage

// ----- rtl/core/keyframe_table_interpolator.sv -----
// Keyframe table interpolator: sequencer, register port and output word
// Sequence: a resize or a rejected command goes straight to the output word; set by index,
//   remove and empty insert go to apply; a sample, set by time or insert locates first,
//   with a binary search when timed; a blend adds multiply and blend, and a divide when timed.
// Throughput: one word at a time; the binary search over the cell row and the divider set it.
// Reset: synchronous active low; clears all cells, count, outputs; interval mode set to fixed.
`timescale 1ns / 1ps
module keyframe_table_interpolator
    import kti_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_command,
    input  logic [15:0]              i_sample_time,
    input  logic signed [31:0]       i_key_value,
    input  logic [6:0]               i_entry_index,
    input  logic                     i_interpolate,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [31:0]       o_result_value,
    output logic [5:0]               o_found_index,
    output logic [1:0]               o_status,
    output logic [6:0]               o_entry_count
);

`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 7) ? CW + 1 : 8;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOCATE = 10'b0000000010,
        S_SEARCH = 10'b0000000100,
        S_POST   = 10'b0000001000,
        S_PREP   = 10'b0000010000,
        S_DIV    = 10'b0000100000,
        S_MUL    = 10'b0001000000,
        S_BLEND  = 10'b0010000000,
        S_APPLY  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [TIME_W-1:0]        r_t;
    logic signed [VAL_W-1:0]  r_val;
    logic                     r_interp;
    logic                     r_fixed;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_idx, r_si, r_ei_s;
    logic [FRAC_W-1:0]        r_frac;
    logic signed [VAL_W-1:0]  r_a, r_b, r_res;
    logic signed [50:0]       r_prod;
    t_status                  r_status;

    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_value;
    logic [5:0]               r_out_found;
    t_status                  r_out_status;
    logic [6:0]               r_out_count;

    logic                     w_accept, w_cfg_wr, w_out_free;
    t_cell_ctl                w_ctl;
    logic [AW-1:0]            w_rd_a, w_rd_b, w_mid, w_last;
    logic signed [VAL_W-1:0]  w_va, w_vb;
    logic [TIME_W-1:0]        w_ta, w_tb;
    logic [TIME_W+CW-1:0]     w_fprod;
    logic                     w_div_start, w_div_done;
    logic [TIME_W-1:0]        w_quot;
    logic [EW-1:0]            w_ei_x, w_cnt_x;
    logic [CW:0]              w_next_x;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign pready     = 1'b1;
    assign prdata     = (paddr == ADDR_FIXED) ? {31'd0, r_fixed} : 32'd0;

    assign w_last   = AW'(r_count - 1'b1);
    assign w_mid    = AW'(({1'b0, r_si} + {1'b0, r_ei_s}) >> 1);
    assign w_fprod  = (TIME_W+CW)'(r_t) * (TIME_W+CW)'(r_count);
    assign w_ei_x   = EW'(i_entry_index);
    assign w_cnt_x  = EW'(r_count);
    assign w_next_x = (CW+1)'(r_idx) + 1'b1;

    // read address of the first port follows the step in progress
    always_comb begin
        priority case (1'b1)
            r_state == S_LOCATE: w_rd_a = w_last;
            r_state == S_SEARCH: w_rd_a = w_mid;
            default:             w_rd_a = r_idx;
        endcase
    end
    assign w_rd_b = AW'(w_next_x);

    // broadcast the table update to the cells
    always_comb begin
        w_ctl.op      = CELL_HOLD;
        w_ctl.time_en = !r_fixed;
        if (r_state == S_APPLY) begin
            unique case (r_cmd)
                CMD_SET_TIME, CMD_SET_IDX: w_ctl.op = CELL_WRITE;
                CMD_INSERT:                w_ctl.op = CELL_INSERT;
                CMD_REMOVE:                w_ctl.op = CELL_REMOVE;
                default:                   w_ctl.op = CELL_HOLD;
            endcase
        end
    end

    kti_chain #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_pos       (r_idx),
        .i_count     (r_count),
        .i_new_value (r_val),
        .i_new_time  (r_t),
        .i_rd_a      (w_rd_a),
        .i_rd_b      (w_rd_b),
        .o_value_a   (w_va),
        .o_time_a    (w_ta),
        .o_value_b   (w_vb),
        .o_time_b    (w_tb)
    );

    assign w_div_start = (r_state == S_PREP) && r_interp && (w_next_x < (CW+1)'(r_count))
                         && !r_fixed && (w_tb > w_ta) && (r_t > w_ta) && (r_t < w_tb);

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_t - w_ta),
        .i_den   (w_tb - w_ta),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmd        <= CMD_SAMPLE;
            r_t          <= '0;
            r_val        <= '0;
            r_interp     <= 1'b0;
            r_fixed      <= 1'b1;
            r_count      <= '0;
            r_idx        <= '0;
            r_si         <= '0;
            r_ei_s       <= '0;
            r_frac       <= '0;
            r_a          <= '0;
            r_b          <= '0;
            r_res        <= '0;
            r_prod       <= '0;
            r_status     <= ST_OK;
            r_out_valid  <= 1'b0;
            r_out_value  <= '0;
            r_out_found  <= '0;
            r_out_status <= ST_OK;
            r_out_count  <= '0;
        end else begin
            if (w_cfg_wr && paddr == ADDR_FIXED) r_fixed <= pwdata[0];
            // drop the taken word unless a new one replaces it below
            if (r_out_valid && !i_out_stall && r_state != S_DONE) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= t_cmd'(i_command);
                        r_t      <= i_sample_time;
                        r_val    <= i_key_value;
                        r_interp <= i_interpolate;
                        r_idx    <= '0;
                        r_res    <= '0;
                        r_status <= ST_OK;
                        r_state  <= S_DONE;
                        unique case (t_cmd'(i_command))
                            CMD_SAMPLE, CMD_SET_TIME: begin
                                if (r_count == '0) r_status <= ST_EMPTY;
                                else r_state <= S_LOCATE;
                            end
                            CMD_SET_IDX, CMD_REMOVE: begin
                                if (r_count == '0) r_status <= ST_EMPTY;
                                else if (w_ei_x >= w_cnt_x) r_status <= ST_RANGE;
                                else begin
                                    r_idx   <= AW'(i_entry_index);
                                    r_state <= S_APPLY;
                                end
                            end
                            CMD_INSERT: begin
                                if (r_count >= CW'(DEPTH)) r_status <= ST_FULL;
                                else if (r_count == '0) r_state <= S_APPLY;
                                else r_state <= S_LOCATE;
                            end
                            CMD_RESIZE: begin
                                if (w_ei_x > EW'(DEPTH)) r_status <= ST_RANGE;
                                else r_count <= CW'(i_entry_index);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LOCATE: begin
                    if (r_fixed) begin
                        r_idx   <= AW'(w_fprod >> TIME_W);
                        r_frac  <= {1'b0, w_fprod[TIME_W-1:0]};
                        r_state <= S_POST;
                    end else if (r_t >= w_ta) begin
                        r_idx   <= w_last;
                        r_state <= S_POST;
                    end else begin
                        r_si    <= '0;
                        r_ei_s  <= w_last;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    // one halving step per cycle
                    if (r_ei_s - r_si > AW'(1)) begin
                        if (w_ta < r_t) r_si <= w_mid;
                        else if (w_ta > r_t) r_ei_s <= w_mid;
                        else begin
                            r_idx   <= w_mid;
                            r_state <= S_POST;
                        end
                    end else begin
                        r_idx   <= r_si;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    unique case (r_cmd)
                        CMD_SAMPLE: r_state <= S_PREP;
                        CMD_INSERT: begin
                            r_idx   <= AW'(w_next_x);
                            r_state <= S_APPLY;
                        end
                        default: r_state <= S_APPLY;
                    endcase
                end
                S_PREP: begin
                    r_a   <= w_va;
                    r_b   <= w_vb;
                    r_res <= w_va;
                    if (!r_interp || w_next_x >= (CW+1)'(r_count)) r_state <= S_DONE;
                    else if (r_fixed) r_state <= S_MUL;
                    else if (w_tb <= w_ta) r_state <= S_DONE;
                    else if (r_t <= w_ta) begin
                        r_frac  <= '0;
                        r_state <= S_MUL;
                    end else if (r_t >= w_tb) begin
                        r_frac  <= FRAC_W'(1) << TIME_W;
                        r_state <= S_MUL;
                    end else r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_frac  <= {1'b0, w_quot};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 51'(33'(r_b) - 33'(r_a)) * $signed({2'b00, r_frac});
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    // floor of the scaled difference
                    r_res   <= r_a + r_prod[47:16];
                    r_state <= S_DONE;
                end
                S_APPLY: begin
                    if (r_cmd == CMD_INSERT) r_count <= r_count + 1'b1;
                    else if (r_cmd == CMD_REMOVE) r_count <= r_count - 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res;
                        r_out_found  <= 6'(r_idx);
                        r_out_status <= r_status;
                        r_out_count  <= 7'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_found_index  = r_out_found;
    assign o_status       = r_out_status;
    assign o_entry_count  = r_out_count;

    `KTI_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH))
    `KTI_ASSERT_NEXT(a_busy_after_accept, w_accept, o_in_stall)
    `KTI_ASSERT_IMPL(a_full_only_insert, r_state == S_DONE && r_status == ST_FULL,
        r_cmd == CMD_INSERT && r_count == CW'(DEPTH))

endmodule

// ----- rtl/core/kti_cell.sv -----
// One keyframe cell: holds a value and a time, shifts with its neighbors
`timescale 1ns / 1ps
module kti_cell
    import kti_pkg::*;
#(
    parameter int IDX = 0,
    parameter int AW  = 6,
    parameter int CW  = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [AW-1:0]            i_pos,
    input  logic [CW-1:0]            i_count,
    input  logic signed [VAL_W-1:0]  i_new_value,
    input  logic [TIME_W-1:0]        i_new_time,
    input  logic signed [VAL_W-1:0]  i_prev_value,
    input  logic [TIME_W-1:0]        i_prev_time,
    input  logic signed [VAL_W-1:0]  i_next_value,
    input  logic [TIME_W-1:0]        i_next_time,
    output logic signed [VAL_W-1:0]  o_value,
    output logic [TIME_W-1:0]        o_time
);

    localparam logic [CW:0] IDX_C = (CW+1)'(IDX);

    logic signed [VAL_W-1:0] r_value, n_value;
    logic [TIME_W-1:0]       r_time, n_time;
    logic [CW:0]             w_pos, w_count;

    assign w_pos   = (CW+1)'(i_pos);
    assign w_count = (CW+1)'(i_count);

    // pick the new contents from the broadcast operation
    always_comb begin
        n_value = r_value;
        n_time  = r_time;
        unique case (i_ctl.op)
            CELL_WRITE: begin
                if (w_pos == IDX_C) n_value = i_new_value;
            end
            CELL_INSERT: begin
                if (w_pos == IDX_C) begin
                    n_value = i_new_value;
                    if (i_ctl.time_en) n_time = i_new_time;
                end else if (IDX_C > w_pos && IDX_C <= w_count) begin
                    n_value = i_prev_value;
                    if (i_ctl.time_en) n_time = i_prev_time;
                end
            end
            CELL_REMOVE: begin
                if (IDX_C >= w_pos && IDX_C + 1'b1 < w_count) begin
                    n_value = i_next_value;
                    if (i_ctl.time_en) n_time = i_next_time;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_time  <= '0;
        end else begin
            r_value <= n_value;
            r_time  <= n_time;
        end
    end

    assign o_value = r_value;
    assign o_time  = r_time;

endmodule

// ----- rtl/core/kti_chain.sv -----
// Row of keyframe cells with two read ports
`timescale 1ns / 1ps
module kti_chain
    import kti_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [AW-1:0]            i_pos,
    input  logic [CW-1:0]            i_count,
    input  logic signed [VAL_W-1:0]  i_new_value,
    input  logic [TIME_W-1:0]        i_new_time,
    input  logic [AW-1:0]            i_rd_a,
    input  logic [AW-1:0]            i_rd_b,
    output logic signed [VAL_W-1:0]  o_value_a,
    output logic [TIME_W-1:0]        o_time_a,
    output logic signed [VAL_W-1:0]  o_value_b,
    output logic [TIME_W-1:0]        o_time_b
);

    logic signed [VAL_W-1:0] w_value [DEPTH];
    logic [TIME_W-1:0]       w_time  [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [VAL_W-1:0] w_pv, w_nv;
            logic [TIME_W-1:0]       w_pt, w_nt;
            if (g == 0) begin : g_first
                assign w_pv = '0;
                assign w_pt = '0;
            end else begin : g_mid_lo
                assign w_pv = w_value[g-1];
                assign w_pt = w_time[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_nv = '0;
                assign w_nt = '0;
            end else begin : g_mid_hi
                assign w_nv = w_value[g+1];
                assign w_nt = w_time[g+1];
            end
            kti_cell #(.IDX(g), .AW(AW), .CW(CW)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_pos        (i_pos),
                .i_count      (i_count),
                .i_new_value  (i_new_value),
                .i_new_time   (i_new_time),
                .i_prev_value (w_pv),
                .i_prev_time  (w_pt),
                .i_next_value (w_nv),
                .i_next_time  (w_nt),
                .o_value      (w_value[g]),
                .o_time       (w_time[g])
            );
        end
    endgenerate

    // select the addressed cells
    always_comb begin
        o_value_a = '0;
        o_time_a  = '0;
        o_value_b = '0;
        o_time_b  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (i_rd_a == AW'(k)) begin
                o_value_a = w_value[k];
                o_time_a  = w_time[k];
            end
            if (i_rd_b == AW'(k)) begin
                o_value_b = w_value[k];
                o_time_b  = w_time[k];
            end
        end
    end

endmodule

// ----- rtl/core/kti_div.sv -----
// Serial restoring divider for the blend fraction, one quotient bit a cycle
`timescale 1ns / 1ps
module kti_div
    import kti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_num,
    input  logic [TIME_W-1:0] i_den,
    output logic [TIME_W-1:0] o_quot,
    output logic              o_done
);

    logic [TIME_W-1:0]         r_rem, r_den, r_quot;
    logic [$clog2(TIME_W)-1:0] r_cnt;
    logic                      r_busy, r_done;
    logic [TIME_W:0]           w_shift;
    logic                      w_ge;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_den  <= '0;
            r_quot <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                // shift in one quotient bit
                r_rem  <= w_ge ? TIME_W'(w_shift - {1'b0, r_den}) : TIME_W'(w_shift);
                r_quot <= {r_quot[TIME_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule
